@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an implication holds on the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/shbb_pkg.sv @@
`default_nettype none

package shbb_pkg;

  localparam logic [7:0] CODE_RAISE = 8'h34;  // '4'
  localparam logic [7:0] CODE_LOWER = 8'h32;  // '2'

  // echo / 148 = (echo >> 2) / 37, done as a reciprocal multiply
  localparam int unsigned ECHO_DROP  = 2;
  localparam int unsigned ECHO_Q_W   = 16 - ECHO_DROP;
  localparam int unsigned RECIP_SH   = 19;
  localparam logic [13:0] RECIP_37   = 14'd14170;
  localparam int unsigned PROD_W     = 2 * ECHO_Q_W;
  localparam int unsigned QUOT_W     = PROD_W - RECIP_SH;

  localparam logic [7:0] RST_MIN_SPEED  = 8'd85;
  localparam logic [7:0] RST_MAX_SPEED  = 8'd175;
  localparam logic [7:0] RST_BOOST_THR  = 8'd90;
  localparam logic [3:0] RST_BOOST_STEP = 4'd3;
  localparam logic [3:0] RST_FINE_STEP  = 4'd1;
  localparam logic [5:0] RST_DIST_LOW   = 6'd1;
  localparam logic [5:0] RST_DIST_HIGH  = 6'd20;
  localparam logic [3:0] RST_MARGIN     = 4'd0;
  localparam logic [7:0] RST_SPEED      = 8'd0;
  localparam logic [5:0] RST_SETPOINT   = 6'd8;

  typedef enum logic [2:0] {
    REG_MIN_SPEED  = 3'd0,
    REG_MAX_SPEED  = 3'd1,
    REG_BOOST_THR  = 3'd2,
    REG_BOOST_STEP = 3'd3,
    REG_FINE_STEP  = 3'd4,
    REG_DIST_LOW   = 3'd5,
    REG_DIST_HIGH  = 3'd6,
    REG_MARGIN     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] min_speed;
    logic [7:0] max_speed;
    logic [7:0] boost_threshold;
    logic [3:0] boost_step;
    logic [3:0] fine_step;
    logic [5:0] dist_low;
    logic [5:0] dist_high;
    logic [3:0] margin;
  } cfg_t;

  typedef struct packed {
    logic [7:0] speed;
    logic [5:0] setpoint;
    logic       indicator;
  } ctl_state_t;

  typedef struct packed {
    logic       msg_valid;
    logic [7:0] button_char;
    logic [15:0] echo_width_us;
  } sample_t;

  typedef struct packed {
    logic [7:0] motor_speed;
    logic       at_target;
    logic       speed_changed;
    logic [5:0] distance_in;
    logic [5:0] setpoint;
  } result_t;

  // Above max is checked first: when the limits cross, values above max get max and all others get min.
  function automatic logic [7:0] clamp_speed(input logic signed [9:0] v,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic [7:0] res;
    if (v > $signed({2'b00, hi})) begin
      res = hi;
    end else if (v < $signed({2'b00, lo})) begin
      res = lo;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/shbb_step.sv @@
`default_nettype none

module shbb_step #(
  parameter int unsigned ZERO_RUN_LIMIT = 5,
  parameter int unsigned ZR_W           = 3
) (
  input  shbb_pkg::cfg_t       cfg,
  input  shbb_pkg::ctl_state_t cur,
  input  logic [ZR_W-1:0]      zero_run,
  input  shbb_pkg::sample_t    smp,
  output shbb_pkg::ctl_state_t nxt,
  output logic [ZR_W-1:0]      zero_run_nxt,
  output shbb_pkg::result_t    res
);
  import shbb_pkg::*;

  localparam logic [ZR_W-1:0] ZR_LIMIT = ZR_W'(ZERO_RUN_LIMIT);

  logic [6:0]          raise_cand;
  logic [6:0]          lower_cand;
  logic                raise_ok;
  logic                lower_ok;
  logic [5:0]          sp;
  logic [ECHO_Q_W-1:0] echo_q;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;
  logic [5:0]          inches;
  logic                in_band;
  logic [3:0]          inc;
  logic signed [9:0]   up_val;
  logic signed [9:0]   down_val;

  // Setpoint moves first; the sonar decision sees the new value.
  always_comb begin
    raise_cand = {1'b0, cur.setpoint} + 7'd1;
    lower_cand = {1'b0, cur.setpoint} - 7'd1;
    raise_ok   = (raise_cand <= {1'b0, cfg.dist_high}) && (raise_cand >= {1'b0, cfg.dist_low});
    lower_ok   = (cur.setpoint != 6'd0) && (lower_cand <= {1'b0, cfg.dist_high})
                 && (lower_cand >= {1'b0, cfg.dist_low});
    sp = cur.setpoint;
    if (smp.msg_valid) begin
      if ((smp.button_char == CODE_RAISE) && raise_ok) begin
        sp = raise_cand[5:0];
      end else if ((smp.button_char == CODE_LOWER) && lower_ok) begin
        sp = lower_cand[5:0];
      end
    end
  end

  assign echo_q = smp.echo_width_us[15:ECHO_DROP];
  assign prod   = {{(PROD_W-ECHO_Q_W){1'b0}}, echo_q} * {{(PROD_W-14){1'b0}}, RECIP_37};
  assign quot   = prod[PROD_W-1:RECIP_SH];

  always_comb begin
    if (quot >= {{(QUOT_W-6){1'b0}}, cfg.dist_high}) begin
      inches = 6'd0;
    end else begin
      inches = quot[5:0];
    end
  end

  assign in_band = (({1'b0, inches} + {3'b000, cfg.margin}) >= {1'b0, sp})
                   && ({1'b0, inches} <= ({1'b0, sp} + {3'b000, cfg.margin}));
  assign inc      = (cur.speed <= cfg.boost_threshold) ? cfg.boost_step : cfg.fine_step;
  assign up_val   = $signed({2'b00, cur.speed}) + $signed({6'd0, inc});
  assign down_val = $signed({2'b00, cur.speed}) - $signed({6'd0, cfg.fine_step});

  always_comb begin
    nxt               = cur;
    nxt.setpoint      = sp;
    zero_run_nxt      = zero_run;
    res.speed_changed = 1'b0;
    if (inches == 6'd0) begin
      // count empty readings; hold minimum speed once the run is long enough
      if (zero_run == ZR_LIMIT) begin
        nxt.speed = clamp_speed($signed({2'b00, cfg.min_speed}), cfg.min_speed,
                                cfg.max_speed);
      end else begin
        zero_run_nxt = zero_run + ZR_W'(1);
      end
    end else begin
      zero_run_nxt = '0;
      if (in_band) begin
        nxt.indicator = 1'b1;
      end else begin
        nxt.indicator     = 1'b0;
        res.speed_changed = 1'b1;
        if (inches <= sp) begin
          nxt.speed = clamp_speed(up_val, cfg.min_speed, cfg.max_speed);
        end else begin
          nxt.speed = clamp_speed(down_val, cfg.min_speed, cfg.max_speed);
        end
      end
    end
    res.motor_speed = nxt.speed;
    res.at_target   = nxt.indicator;
    res.distance_in = inches;
    res.setpoint    = sp;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sonar_height_bang_bang_controller.sv @@
// Flow: a beat taken at one edge is held in the input register, worked by shbb_step
// and registered into the result register, once that is free, which drives the out_ ports.
// Throughput: one beat per cycle while out_stall is low; the single pass through the input register,
// divide-by-148 multiply and speed clamp sets that rate.
// Reset (synchronous, rst_n low): both stages empty, registers at their
// defaults, speed 0, setpoint 8, zero run and indicator cleared.
`default_nettype none

module sonar_height_bang_bang_controller #(
  parameter int unsigned ZERO_RUN_LIMIT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_msg_valid,
  input  logic [7:0]  in_button_char,
  input  logic [15:0] in_echo_width_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_motor_speed,
  output logic        out_at_target,
  output logic        out_speed_changed,
  output logic [5:0]  out_distance_in,
  output logic [5:0]  out_setpoint
);
  import shbb_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned ZR_W = $clog2(ZERO_RUN_LIMIT + 1);

  cfg_t            cfg_r;
  ctl_state_t      st_r;
  ctl_state_t      st_nxt;
  logic [ZR_W-1:0] zero_run_r;
  logic [ZR_W-1:0] zero_run_nxt;
  sample_t         smp_r;
  logic            s1_valid_r;
  result_t         res_r;
  result_t         res_nxt;
  logic            out_valid_r;
  logic            advance;

  // The work stage moves on whenever the result register is free or drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_speed       <= RST_MIN_SPEED;
      cfg_r.max_speed       <= RST_MAX_SPEED;
      cfg_r.boost_threshold <= RST_BOOST_THR;
      cfg_r.boost_step      <= RST_BOOST_STEP;
      cfg_r.fine_step       <= RST_FINE_STEP;
      cfg_r.dist_low        <= RST_DIST_LOW;
      cfg_r.dist_high       <= RST_DIST_HIGH;
      cfg_r.margin          <= RST_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MIN_SPEED:  cfg_r.min_speed       <= cfg_wdata;
        REG_MAX_SPEED:  cfg_r.max_speed       <= cfg_wdata;
        REG_BOOST_THR:  cfg_r.boost_threshold <= cfg_wdata;
        REG_BOOST_STEP: cfg_r.boost_step      <= cfg_wdata[3:0];
        REG_FINE_STEP:  cfg_r.fine_step       <= cfg_wdata[3:0];
        REG_DIST_LOW:   cfg_r.dist_low        <= cfg_wdata[5:0];
        REG_DIST_HIGH:  cfg_r.dist_high       <= cfg_wdata[5:0];
        REG_MARGIN:     cfg_r.margin          <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  shbb_step #(
    .ZERO_RUN_LIMIT (ZERO_RUN_LIMIT),
    .ZR_W           (ZR_W)
  ) u_step (
    .cfg          (cfg_r),
    .cur          (st_r),
    .zero_run     (zero_run_r),
    .smp          (smp_r),
    .nxt          (st_nxt),
    .zero_run_nxt (zero_run_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.speed     <= RST_SPEED;
      st_r.setpoint  <= RST_SETPOINT;
      st_r.indicator <= 1'b0;
      zero_run_r     <= '0;
    end else begin
      // the input register fills whenever it is free, even while the result waits
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          st_r       <= st_nxt;
          zero_run_r <= zero_run_nxt;
        end
      end
    end
  end

  // payload: capture on an accepted beat, publish as the work stage drains
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp_r.msg_valid     <= in_msg_valid;
      smp_r.button_char   <= in_button_char;
      smp_r.echo_width_us <= in_echo_width_us;
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_speed   = res_r.motor_speed;
  assign out_at_target     = res_r.at_target;
  assign out_speed_changed = res_r.speed_changed;
  assign out_distance_in   = res_r.distance_in;
  assign out_setpoint      = res_r.setpoint;

  `ASSERT_CLK(a_zero_run_bound, zero_run_r <= ZR_W'(ZERO_RUN_LIMIT),
              "zero run counted past its limit")
  `ASSERT_CLK(a_step_clears_lamp, !(out_valid_r && res_r.speed_changed && res_r.at_target),
              "speed stepped while indicator lit")
  `ASSERT_CLK(a_step_needs_echo, !(out_valid_r && res_r.speed_changed && res_r.distance_in == 6'd0),
              "speed stepped on an empty reading")
  `ASSERT_NEXT(a_work_reaches_out, s1_valid_r && advance, out_valid_r,
               "worked beat did not reach the result register")
  `ASSERT_NEXT(a_state_holds_idle, !s1_valid_r || !advance, $stable(st_r) && $stable(zero_run_r),
               "control state moved without a beat")

endmodule

`default_nettype wire
